// ===== hw/rtl/poq_pkg.sv =====
// Shared types and codes for the priority order queue.
package poq_pkg;

  typedef enum logic [2:0] {
    FN_APPEND    = 3'd0,
    FN_REPLACE   = 3'd1,
    FN_INTERRUPT = 3'd2,
    FN_COMPLETE  = 3'd3,
    FN_FAIL      = 3'd4,
    FN_CANCEL    = 3'd5,
    FN_TICK      = 3'd6,
    FN_CLEAR     = 3'd7
  } func_t;

  localparam logic [2:0] ST_QUEUED    = 3'd0;
  localparam logic [2:0] ST_ACTIVE    = 3'd1;
  localparam logic [2:0] ST_COMPLETED = 3'd2;
  localparam logic [2:0] ST_FAILED    = 3'd3;
  localparam logic [2:0] ST_CANCELLED = 3'd4;

  localparam logic [3:0] RSN_NONE        = 4'd0;
  localparam logic [3:0] RSN_REPLACED    = 4'd1;
  localparam logic [3:0] RSN_INTERRUPTED = 4'd2;
  localparam logic [3:0] RSN_TIMEOUT     = 4'd3;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_REJECTED = 2'd1;
  localparam logic [1:0] STS_FULL     = 2'd2;

  localparam logic REC_ACK   = 1'b0;
  localparam logic REC_EVENT = 1'b1;

  typedef struct packed {
    logic [2:0]         func;
    logic [7:0]         kind_code;
    logic signed [15:0] priority_req;
    logic [15:0]        timeout_ticks;
    logic [31:0]        order_id;
    logic [3:0]         reason_code;
    logic [7:0]         tick_count;
  } cmd_t;

  typedef struct packed {
    logic        record_type;
    logic [1:0]  status;
    logic [31:0] result_id;
    logic [7:0]  event_kind;
    logic [2:0]  from_state;
    logic [2:0]  to_state;
    logic [3:0]  event_reason;
    logic [31:0] sequence_res;
    logic        last;
  } rec_t;

  typedef struct packed {
    logic [31:0]        id;
    logic [7:0]         kind;
    logic signed [15:0] prio;
    logic [15:0]        tmo;
  } entry_t;

endpackage

// ===== hw/rtl/poq_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module poq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/priority_order_queue_unit.sv =====
// Top level of the priority order queue: command sequencer around the wait-queue RAM.
// A command that only acknowledges produces just its ack record; each event comes before it.
// Walking the queue (replace, cancel search, insertion, removal after activation)
// takes a read state and a follow-up state per entry, as the single queue RAM has registered read data.
// Commands are taken one at a time; the next is accepted while the final ack waits.
// Synchronous reset empties the queue and active slot and sets ids and sequence to one.
module priority_order_queue_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  poq_pkg::cmd_t   cmd,
  output logic            rec_valid,
  input  logic            rec_ready,
  output poq_pkg::rec_t   rec
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int EW = $bits(poq_pkg::entry_t);

  typedef enum logic [4:0] {
    S_IDLE, S_EMIT_END, S_REP_RD, S_REP_EMIT, S_CR_Q, S_CR_A, S_INS_RD, S_INS_CHK,
    S_ACT_RD, S_ACT_DAT, S_SH_RD, S_SH_WR, S_ACT_EMIT, S_SR_RD, S_SR_CHK, S_CAN_EMIT,
    S_ACK
  } state_t;

  typedef enum logic [1:0] {AE_REPLACE, AE_CREATE, AE_ACTIVATE} after_t;

  state_t             st;
  after_t             after_end;
  logic               ret_cancel;
  logic               cr_now;
  poq_pkg::cmd_t      cur;
  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic               active_valid;
  logic [31:0]        active_id;
  logic [7:0]         active_kind;
  logic signed [15:0] active_priority;
  logic [15:0]        active_timeout;
  logic [15:0]        active_elapsed;
  logic [31:0]        next_id;
  logic [31:0]        next_seq;
  logic [31:0]        new_id;
  logic [1:0]         ack_status;
  logic [31:0]        ack_id;
  logic [2:0]         end_to;
  logic [3:0]         end_reason;
  logic [7:0]         cancel_kind;

  state_t             st_next;
  after_t             after_end_next;
  logic               cr_now_next;
  logic [1:0]         ack_status_next;
  logic [31:0]        ack_id_next;
  logic [2:0]         end_to_next;
  logic [3:0]         end_reason_next;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  poq_pkg::entry_t    ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [EW-1:0]      ram_rbits;
  poq_pkg::entry_t    rd;
  poq_pkg::entry_t    new_entry;
  logic               can_emit;
  logic               rec_load;
  logic [CW-1:0]      idx_inc;
  logic [CW-1:0]      idx_dec;
  logic [16:0]        tick_sum;
  logic [15:0]        tick_sat;

  assign rd        = poq_pkg::entry_t'(ram_rbits);
  assign cmd_ready = (st == S_IDLE);
  assign can_emit  = !rec_valid || rec_ready;
  assign rec_load  = can_emit && (st inside {S_EMIT_END, S_REP_EMIT, S_CR_Q, S_CR_A,
                                             S_ACT_EMIT, S_CAN_EMIT, S_ACK});
  assign idx_inc   = idx + CW'(1);
  assign idx_dec   = idx - CW'(1);
  assign tick_sum  = {1'b0, active_elapsed} + {9'd0, cmd.tick_count};
  assign tick_sat  = tick_sum[16] ? 16'hFFFF : tick_sum[15:0];

  always_comb begin
    new_entry.id   = new_id;
    new_entry.kind = cur.kind_code;
    new_entry.prio = cur.priority_req;
    new_entry.tmo  = cur.timeout_ticks;
  end

  always_comb begin
    st_next         = S_ACK;
    ack_status_next = poq_pkg::STS_OK;
    ack_id_next     = 32'd0;
    cr_now_next     = 1'b1;
    end_to_next     = end_to;
    end_reason_next = end_reason;
    after_end_next  = after_end;
    case (poq_pkg::func_t'(cmd.func))
      poq_pkg::FN_APPEND: begin
        if (cmd.kind_code == 8'd0) begin
          ack_status_next = poq_pkg::STS_REJECTED;
        end else if (active_valid && count >= CW'(QUEUE_DEPTH)) begin
          ack_status_next = poq_pkg::STS_FULL;
        end else begin
          cr_now_next = !active_valid;
          st_next     = S_CR_Q;
        end
      end
      poq_pkg::FN_REPLACE: begin
        if (cmd.kind_code == 8'd0) begin
          ack_status_next = poq_pkg::STS_REJECTED;
        end else if (active_valid) begin
          end_to_next     = poq_pkg::ST_CANCELLED;
          end_reason_next = poq_pkg::RSN_REPLACED;
          after_end_next  = AE_REPLACE;
          st_next         = S_EMIT_END;
        end else begin
          st_next = S_REP_RD;
        end
      end
      poq_pkg::FN_INTERRUPT: begin
        if (cmd.kind_code == 8'd0 ||
            (active_valid && cmd.priority_req < active_priority)) begin
          ack_status_next = poq_pkg::STS_REJECTED;
        end else if (active_valid) begin
          end_to_next     = poq_pkg::ST_CANCELLED;
          end_reason_next = poq_pkg::RSN_INTERRUPTED;
          after_end_next  = AE_CREATE;
          st_next         = S_EMIT_END;
        end else begin
          st_next = S_CR_Q;
        end
      end
      poq_pkg::FN_COMPLETE, poq_pkg::FN_FAIL: begin
        ack_id_next = cmd.order_id;
        if (active_valid && active_id == cmd.order_id) begin
          if (cmd.func == poq_pkg::FN_COMPLETE) begin
            end_to_next     = poq_pkg::ST_COMPLETED;
            end_reason_next = poq_pkg::RSN_NONE;
          end else begin
            end_to_next     = poq_pkg::ST_FAILED;
            end_reason_next = cmd.reason_code;
          end
          after_end_next = AE_ACTIVATE;
          st_next        = S_EMIT_END;
        end else begin
          ack_status_next = poq_pkg::STS_REJECTED;
        end
      end
      poq_pkg::FN_CANCEL: begin
        ack_id_next = cmd.order_id;
        if (active_valid && active_id == cmd.order_id) begin
          end_to_next     = poq_pkg::ST_CANCELLED;
          end_reason_next = cmd.reason_code;
          after_end_next  = AE_ACTIVATE;
          st_next         = S_EMIT_END;
        end else begin
          st_next = S_SR_RD;
        end
      end
      poq_pkg::FN_TICK: begin
        if (active_valid && cmd.tick_count != 8'd0 && active_timeout != 16'd0 &&
            tick_sat >= active_timeout) begin
          end_to_next     = poq_pkg::ST_FAILED;
          end_reason_next = poq_pkg::RSN_TIMEOUT;
          after_end_next  = AE_ACTIVATE;
          st_next         = S_EMIT_END;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = idx[AW-1:0];
    ram_we    = 1'b0;
    ram_waddr = idx[AW-1:0];
    ram_wdata = rd;
    case (st)
      S_REP_RD, S_SR_RD: begin
        ram_re = (idx != count);
      end
      S_INS_RD: begin
        ram_re    = (idx != '0);
        ram_raddr = idx_dec[AW-1:0];
      end
      S_ACT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      S_SH_RD: begin
        ram_re    = (idx_inc < count);
        ram_raddr = idx_inc[AW-1:0];
      end
      S_SH_WR: begin
        ram_we = 1'b1;
      end
      S_INS_CHK: begin
        ram_we = 1'b1;
        if (idx == '0 || rd.prio >= cur.priority_req) begin
          ram_wdata = new_entry;
        end
      end
      default: begin
      end
    endcase
  end

  poq_ram #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_wait_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rbits)
  );

  function automatic poq_pkg::rec_t make_event(logic [31:0] id, logic [7:0] kind,
                                               logic [2:0] from, logic [2:0] to,
                                               logic [3:0] reason, logic [31:0] seq);
    poq_pkg::rec_t r;
    r.record_type  = poq_pkg::REC_EVENT;
    r.status       = poq_pkg::STS_OK;
    r.result_id    = id;
    r.event_kind   = kind;
    r.from_state   = from;
    r.to_state     = to;
    r.event_reason = reason;
    r.sequence_res = seq;
    r.last         = 1'b0;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= S_IDLE;
      count        <= '0;
      idx          <= '0;
      active_valid <= 1'b0;
      next_id      <= 32'd1;
      next_seq     <= 32'd1;
      rec_valid    <= 1'b0;
    end else begin
      rec_valid <= rec_load || (rec_valid && !rec_ready);
      case (st)
        S_IDLE: begin
          if (cmd_valid) begin
            cur        <= cmd;
            idx        <= '0;
            ack_status <= ack_status_next;
            ack_id     <= ack_id_next;
            cr_now     <= cr_now_next;
            end_to     <= end_to_next;
            end_reason <= end_reason_next;
            after_end  <= after_end_next;
            st         <= st_next;
            case (poq_pkg::func_t'(cmd.func))
              poq_pkg::FN_TICK: begin
                if (active_valid && cmd.tick_count != 8'd0) begin
                  active_elapsed <= tick_sat;
                end
              end
              poq_pkg::FN_CLEAR: begin
                count           <= '0;
                active_valid    <= 1'b0;
                active_id       <= 32'd0;
                active_kind     <= 8'd0;
                active_priority <= 16'sd0;
                active_timeout  <= 16'd0;
                active_elapsed  <= 16'd0;
                next_id         <= 32'd1;
                next_seq        <= 32'd1;
              end
              default: begin
              end
            endcase
          end
        end
        S_EMIT_END: begin
          if (can_emit) begin
            rec          <= make_event(active_id, active_kind, poq_pkg::ST_ACTIVE, end_to,
                                       end_reason, next_seq);
            next_seq     <= next_seq + 32'd1;
            active_valid <= 1'b0;
            case (after_end)
              AE_REPLACE:  st <= S_REP_RD;
              AE_CREATE:   st <= S_CR_Q;
              default:     st <= (count == '0) ? S_ACK : S_ACT_RD;
            endcase
          end
        end
        S_REP_RD: begin
          if (idx == count) begin
            count <= '0;
            st    <= S_CR_Q;
          end else begin
            st <= S_REP_EMIT;
          end
        end
        S_REP_EMIT: begin
          if (can_emit) begin
            rec       <= make_event(rd.id, rd.kind, poq_pkg::ST_QUEUED, poq_pkg::ST_CANCELLED,
                                    poq_pkg::RSN_REPLACED, next_seq);
            next_seq  <= next_seq + 32'd1;
            idx       <= idx_inc;
            st        <= S_REP_RD;
          end
        end
        S_CR_Q: begin
          if (can_emit) begin
            rec       <= make_event(next_id, cur.kind_code, poq_pkg::ST_QUEUED,
                                    poq_pkg::ST_QUEUED, poq_pkg::RSN_NONE, next_seq);
            next_seq  <= next_seq + 32'd1;
            new_id    <= next_id;
            ack_id    <= next_id;
            next_id   <= next_id + 32'd1;
            idx       <= count;
            st        <= cr_now ? S_CR_A : S_INS_RD;
          end
        end
        S_CR_A: begin
          if (can_emit) begin
            rec             <= make_event(new_id, cur.kind_code, poq_pkg::ST_QUEUED,
                                          poq_pkg::ST_ACTIVE, poq_pkg::RSN_NONE, next_seq);
            next_seq        <= next_seq + 32'd1;
            active_valid    <= 1'b1;
            active_id       <= new_id;
            active_kind     <= cur.kind_code;
            active_priority <= cur.priority_req;
            active_timeout  <= cur.timeout_ticks;
            active_elapsed  <= 16'd0;
            st              <= S_ACK;
          end
        end
        S_INS_RD: begin
          st <= S_INS_CHK;
        end
        S_INS_CHK: begin
          if (idx == '0 || rd.prio >= cur.priority_req) begin
            count <= count + CW'(1);
            st    <= S_ACK;
          end else begin
            idx <= idx_dec;
            st  <= S_INS_RD;
          end
        end
        S_ACT_RD: begin
          st <= S_ACT_DAT;
        end
        S_ACT_DAT: begin
          active_valid    <= 1'b1;
          active_id       <= rd.id;
          active_kind     <= rd.kind;
          active_priority <= rd.prio;
          active_timeout  <= rd.tmo;
          active_elapsed  <= 16'd0;
          idx             <= '0;
          ret_cancel      <= 1'b0;
          st              <= S_SH_RD;
        end
        S_SH_RD: begin
          if (idx_inc < count) begin
            st <= S_SH_WR;
          end else begin
            count <= count - CW'(1);
            st    <= ret_cancel ? S_CAN_EMIT : S_ACT_EMIT;
          end
        end
        S_SH_WR: begin
          idx <= idx_inc;
          st  <= S_SH_RD;
        end
        S_ACT_EMIT: begin
          if (can_emit) begin
            rec       <= make_event(active_id, active_kind, poq_pkg::ST_QUEUED,
                                    poq_pkg::ST_ACTIVE, poq_pkg::RSN_NONE, next_seq);
            next_seq  <= next_seq + 32'd1;
            st        <= S_ACK;
          end
        end
        S_SR_RD: begin
          if (idx == count) begin
            ack_status <= poq_pkg::STS_REJECTED;
            st         <= S_ACK;
          end else begin
            st <= S_SR_CHK;
          end
        end
        S_SR_CHK: begin
          if (rd.id == cur.order_id) begin
            cancel_kind <= rd.kind;
            ret_cancel  <= 1'b1;
            st          <= S_SH_RD;
          end else begin
            idx <= idx_inc;
            st  <= S_SR_RD;
          end
        end
        S_CAN_EMIT: begin
          if (can_emit) begin
            rec       <= make_event(cur.order_id, cancel_kind, poq_pkg::ST_QUEUED,
                                    poq_pkg::ST_CANCELLED, cur.reason_code, next_seq);
            next_seq  <= next_seq + 32'd1;
            st        <= S_ACK;
          end
        end
        S_ACK: begin
          if (can_emit) begin
            rec.record_type  <= poq_pkg::REC_ACK;
            rec.status       <= ack_status;
            rec.result_id    <= ack_id;
            rec.event_kind   <= 8'd0;
            rec.from_state   <= poq_pkg::ST_QUEUED;
            rec.to_state     <= poq_pkg::ST_QUEUED;
            rec.event_reason <= poq_pkg::RSN_NONE;
            rec.sequence_res <= 32'd0;
            rec.last         <= 1'b1;
            st               <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("wait count above queue depth");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (st == S_IDLE && !active_valid) |-> count == '0)
    else $error("queued orders with no active order");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> st != S_IDLE)
    else $error("command transfer produced no work");

endmodule
